### rtl/core/atc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, field widths, codes and character constants of the ANSI
// text terminal core.
// ----------------------------------------------------------------------------
package atc_pkg;

	// default geometry and sequence limits
	localparam int MAX_COLS_DEF = 512;
	localparam int MAX_ROWS_DEF = 200;
	localparam int SEQ_MAX_DEF  = 31;

	// field widths
	localparam int ACT_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int RIDX_W  = 8;
	localparam int CIDX_W  = 9;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 10;
	localparam int CFG_W   = 10;
	localparam int CFGI_W  = 1;
	localparam int PARAM_W = 16;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFGI_W-1:0] REG_HEIGHT = 1'b1;

	// configuration limits
	localparam int MIN_W = 10;
	localparam int MIN_H = 5;

	// item actions
	localparam logic [ACT_W-1:0] ACT_FEED  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CELL  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DIRTY = 2'd2;
	localparam logic [ACT_W-1:0] ACT_ACK   = 2'd3;

	// characters
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1b;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;
	localparam logic [BYTE_W-1:0] CH_QM    = 8'h3f;
	localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5b;
	localparam logic [BYTE_W-1:0] FIN_LO   = 8'h40;
	localparam logic [BYTE_W-1:0] FIN_HI   = 8'h7e;
	localparam logic [BYTE_W-1:0] FIN_CUP  = 8'h48;
	localparam logic [BYTE_W-1:0] FIN_ED   = 8'h4a;
	localparam logic [BYTE_W-1:0] FIN_EL   = 8'h4b;
	localparam logic [BYTE_W-1:0] FIN_SET  = 8'h68;
	localparam logic [BYTE_W-1:0] FIN_RST  = 8'h6c;

	localparam logic [PARAM_W-1:0] ALT_SCREEN_MODE = 16'd1049;
	localparam logic [PARAM_W-1:0] PARAM_SAT       = 16'hffff;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MUL,
		ST_EXEC,
		ST_READ,
		ST_WALK,
		ST_DONE
	} state_t;

	// byte parser modes
	typedef enum logic [1:0] {
		PM_TEXT,
		PM_ESC,
		PM_SEQ
	} pmode_t;

	// memory port controls from the sequencer
	typedef struct packed {
		logic              rd_en;
		logic              rd_alt;
		logic              we_main;
		logic              we_alt;
		logic              wr_copy;
		logic [BYTE_W-1:0] wr_byte;
	} mem_ctl_t;

	// one result item
	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              alt_active;
		logic              full_redraw;
		logic [BYTE_W-1:0] cell_char;
		logic              row_dirty;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/atc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atc_if
// Valid/ready channels of the terminal core: input items and result items.
// ----------------------------------------------------------------------------
interface atc_item_if import atc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [BYTE_W-1:0] data_byte;
	logic [RIDX_W-1:0] row_index;
	logic [CIDX_W-1:0] col_index;

	modport source (output valid, action, data_byte, row_index, col_index, input ready);
	modport sink   (input valid, action, data_byte, row_index, col_index, output ready);
endinterface

interface atc_result_if import atc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;
	logic              alt_active;
	logic              full_redraw;
	logic [BYTE_W-1:0] cell_char;
	logic              row_dirty;

	modport source (output valid, cursor_row, cursor_col, alt_active, full_redraw,
		cell_char, row_dirty, input ready);
	modport sink   (input valid, cursor_row, cursor_col, alt_active, full_redraw,
		cell_char, row_dirty, output ready);
endinterface
`default_nettype wire

### rtl/core/atc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module atc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

### rtl/core/atc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atc_ctrl
// Item sequencer: byte parser, cursor and mode registers, row dirty marks,
// and the screen memory writes and walks for scroll, clear and line erase.
// ----------------------------------------------------------------------------
module atc_ctrl import atc_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int SEQ_MAX  = SEQ_MAX_DEF,
	localparam int DEPTH   = MAX_COLS * MAX_ROWS,
	localparam int AW      = $clog2(DEPTH),
	localparam int EW      = $clog2(MAX_COLS + 1),
	localparam int HW      = $clog2(MAX_ROWS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [EW-1:0]     eff_w,
	input  logic [HW-1:0]     eff_h,
	atc_item_if.sink          item_in,
	output logic              res_load,
	output result_t           res,
	input  logic              slot_free,
	output mem_ctl_t          mem,
	output logic [AW-1:0]     rd_addr,
	output logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] rd_data
);
	localparam int CW  = AW + 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SLW = $clog2(SEQ_MAX + 1);

	state_t state_q, state_n;

	// latched item
	logic [ACT_W-1:0]  act_q;
	logic [BYTE_W-1:0] byte_q;
	logic [RIDX_W-1:0] ridx_q;
	logic [CIDX_W-1:0] cidx_q;

	// terminal state
	logic [ROW_W-1:0]   cur_row_q, sav_row_q;
	logic [COL_W-1:0]   cur_col_q, sav_col_q;
	logic               use_alt_q, needs_full_q;
	logic [MAX_ROWS-1:0] dirty_q;
	pmode_t             pmode_q;
	logic [SLW-1:0]     seq_len_q;
	logic               priv_q;
	logic [1:0]         field_q;
	logic [PARAM_W-1:0] fv_q, sv_q;
	logic               fs_q, ss_q;

	// address arithmetic
	logic [CW-1:0] mul_q, wh_q, lastrow_q;
	logic [ROW_W-1:0] mul_row;

	// memory walk
	logic [CW-1:0] walk_cnt_q, walk_end_q, copy_end_q, init_cnt_q;

	// pending write, issued in the cycle after its read
	logic              pend_v_s1, pend_copy_s1, pend_alt_s1;
	logic [AW-1:0]     pend_addr_s1;
	logic [BYTE_W-1:0] pend_byte_s1;

	logic [BYTE_W-1:0] cell_q;
	logic              rdirty_q;

	// parser next values
	logic [ROW_W-1:0]   nx_row, nx_srow;
	logic [COL_W-1:0]   nx_col, nx_scol;
	logic               nx_alt, nx_full, nx_priv, nx_fs, nx_ss;
	pmode_t             nx_pmode;
	logic [SLW-1:0]     nx_slen;
	logic [1:0]         nx_field;
	logic [PARAM_W-1:0] nx_fv, nx_sv;
	logic               do_scroll, do_clear, do_kline, do_wr, do_dcur;
	logic [PARAM_W-1:0] p0, p1, acc_src, acc_sat, hr, hc;
	logic [19:0]        acc_n;
	logic [10:0]        col_inc, tab_col, w11;
	logic               row_ok, col_ok, row_down, exec_feed, cell_ok;
	logic               walk_go, walk_copy, walk_last;
	logic [CW-1:0]      w_begin, w_end, c_end, cur_addr;

	assign exec_feed = (state_q == ST_EXEC) && (act_q == ACT_FEED);
	assign cell_ok   = (32'(ridx_q) < 32'(eff_h)) && (32'(cidx_q) < 32'(eff_w));
	assign row_ok    = (cur_row_q != '0) && (32'(cur_row_q) <= 32'(eff_h));
	assign col_ok    = (cur_col_q != '0) && (32'(cur_col_q) <= 32'(eff_w));
	assign row_down  = 32'(cur_row_q) < 32'(eff_h);
	assign w11       = 11'(eff_w);
	assign p0        = fs_q ? fv_q : PARAM_W'(1);
	assign p1        = ss_q ? sv_q : PARAM_W'(1);
	assign col_inc   = 11'(cur_col_q) + 11'd1;
	assign tab_col   = ((11'(cur_col_q) + 11'd7) & ~11'd7) + 11'd1;
	assign acc_src   = (field_q == 2'd0) ? fv_q : sv_q;
	assign acc_n     = 20'(acc_src) * 20'd10 + 20'(byte_q - CH_ZERO);
	assign acc_sat   = (acc_n > 20'(PARAM_SAT)) ? PARAM_SAT : acc_n[PARAM_W-1:0];
	assign hr        = (seq_len_q == '0) ? PARAM_W'(1) : p0;
	assign hc        = (seq_len_q == '0) ? PARAM_W'(1) : p1;
	assign cur_addr  = mul_q + CW'(cur_col_q) - CW'(1);

	// byte parser and cursor motion
	always_comb begin
		nx_row = cur_row_q;  nx_col = cur_col_q;
		nx_srow = sav_row_q; nx_scol = sav_col_q;
		nx_alt = use_alt_q;  nx_full = needs_full_q;
		nx_pmode = pmode_q;  nx_slen = seq_len_q; nx_priv = priv_q;
		nx_field = field_q;  nx_fv = fv_q; nx_fs = fs_q; nx_sv = sv_q; nx_ss = ss_q;
		do_scroll = 1'b0; do_clear = 1'b0; do_kline = 1'b0;
		do_wr = 1'b0; do_dcur = 1'b0;
		unique case (pmode_q)
			PM_TEXT: begin
				if (byte_q == CH_ESC) begin
					nx_pmode = PM_ESC;
				end else begin
					case (byte_q)
						CH_LF: begin
							if (row_down) nx_row = cur_row_q + ROW_W'(1);
							else do_scroll = 1'b1;
							nx_col = COL_W'(1);
						end
						CH_CR: nx_col = COL_W'(1);
						CH_BS: if (cur_col_q > COL_W'(1)) nx_col = cur_col_q - COL_W'(1);
						CH_TAB: nx_col = (tab_col > w11) ? COL_W'(eff_w) : COL_W'(tab_col);
						CH_NUL: ;
						default: begin
							do_wr = row_ok && col_ok;
							do_dcur = row_ok && col_ok;
							if (col_inc > w11) begin
								nx_col = COL_W'(1);
								if (row_down) nx_row = cur_row_q + ROW_W'(1);
								else do_scroll = 1'b1;
							end else begin
								nx_col = COL_W'(col_inc);
							end
						end
					endcase
				end
			end
			PM_ESC: begin
				if (byte_q == CH_LBR) begin
					nx_pmode = PM_SEQ; nx_slen = '0; nx_priv = 1'b0; nx_field = 2'd0;
					nx_fv = '0; nx_fs = 1'b0; nx_sv = '0; nx_ss = 1'b0;
				end else begin
					nx_pmode = PM_TEXT;
				end
			end
			PM_SEQ: begin
				if (byte_q >= FIN_LO && byte_q <= FIN_HI) begin
					nx_pmode = PM_TEXT;
					if (priv_q) begin
						if (p0 == ALT_SCREEN_MODE && byte_q == FIN_SET) begin
							nx_alt = 1'b1; nx_srow = cur_row_q; nx_scol = cur_col_q;
							nx_row = ROW_W'(1); nx_col = COL_W'(1);
							do_clear = 1'b1; nx_full = 1'b1;
						end else if (p0 == ALT_SCREEN_MODE && byte_q == FIN_RST) begin
							nx_alt = 1'b0; nx_row = sav_row_q; nx_col = sav_col_q;
							nx_full = 1'b1;
						end
					end else if (byte_q == FIN_CUP) begin
						if (hr == '0) nx_row = ROW_W'(1);
						else if (32'(hr) > 32'(eff_h)) nx_row = ROW_W'(eff_h);
						else nx_row = ROW_W'(hr);
						if (hc == '0) nx_col = COL_W'(1);
						else if (32'(hc) > 32'(eff_w)) nx_col = COL_W'(eff_w);
						else nx_col = COL_W'(hc);
					end else if (byte_q == FIN_ED) begin
						do_clear = (p0 == PARAM_W'(2));
					end else if (byte_q == FIN_EL) begin
						// erase to end of line; a cursor past the width clears nothing
						do_dcur = row_ok;
						do_kline = row_ok && col_ok;
					end
				end else if (byte_q == CH_QM) begin
					nx_priv = 1'b1;
				end else if (32'(seq_len_q) < SEQ_MAX) begin
					nx_slen = seq_len_q + SLW'(1);
					if (byte_q == CH_SEMI) begin
						if (field_q < 2'd2) nx_field = field_q + 2'd1;
					end else if (byte_q >= CH_ZERO && byte_q <= CH_NINE) begin
						if (field_q == 2'd0) begin
							nx_fv = acc_sat; nx_fs = 1'b1;
						end else if (field_q == 2'd1) begin
							nx_sv = acc_sat; nx_ss = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// walk bounds
	assign walk_go = exec_feed && (do_scroll || do_clear || do_kline);
	assign w_begin = do_kline ? cur_addr : '0;
	assign w_end   = do_kline ? mul_q + CW'(eff_w) : wh_q;
	assign c_end   = do_scroll ? lastrow_q : '0;
	assign walk_copy = walk_cnt_q < copy_end_q;
	assign walk_last = (walk_cnt_q + CW'(1)) == walk_end_q;
	assign mul_row = (act_q == ACT_CELL) ? ridx_q : cur_row_q - ROW_W'(1);

	// next state and port controls
	always_comb begin
		state_n      = state_q;
		item_in.ready = 1'b0;
		res_load     = 1'b0;
		mem.rd_en    = 1'b0;
		mem.rd_alt   = use_alt_q;
		mem.we_main  = pend_v_s1 && !pend_alt_s1;
		mem.we_alt   = pend_v_s1 && pend_alt_s1;
		mem.wr_copy  = pend_copy_s1;
		mem.wr_byte  = pend_byte_s1;
		wr_addr      = pend_addr_s1;
		rd_addr      = AW'(walk_cnt_q + CW'(eff_w));
		unique case (state_q)
			ST_INIT: begin
				mem.we_main = 1'b1; mem.we_alt = 1'b1; mem.wr_copy = 1'b0;
				mem.wr_byte = CH_SPACE;
				wr_addr = AW'(init_cnt_q);
				if (init_cnt_q == CW'(DEPTH - 1)) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				item_in.ready = 1'b1;
				if (item_in.valid) state_n = ST_MUL;
			end
			ST_MUL: state_n = ST_EXEC;
			ST_EXEC: begin
				if (act_q == ACT_CELL && cell_ok) begin
					mem.rd_en = 1'b1;
					rd_addr = AW'(mul_q + CW'(cidx_q));
					state_n = ST_READ;
				end else if (walk_go) begin
					state_n = ST_WALK;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_READ: state_n = ST_DONE;
			ST_WALK: begin
				mem.rd_en = walk_copy;
				if (walk_last) state_n = ST_DONE;
			end
			ST_DONE: begin
				res_load = slot_free;
				if (slot_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign res.cursor_row  = cur_row_q;
	assign res.cursor_col  = cur_col_q;
	assign res.alt_active  = use_alt_q;
	assign res.full_redraw = needs_full_q;
	assign res.cell_char   = cell_q;
	assign res.row_dirty   = rdirty_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	// latched item and address products
	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			act_q  <= item_in.action;
			byte_q <= item_in.data_byte;
			ridx_q <= item_in.row_index;
			cidx_q <= item_in.col_index;
		end
		if (state_q == ST_MUL) begin
			mul_q     <= CW'(mul_row * eff_w);
			wh_q      <= CW'(eff_h * eff_w);
			lastrow_q <= CW'((eff_h - HW'(1)) * eff_w);
		end
		if (state_q == ST_EXEC) begin
			cell_q <= (act_q == ACT_CELL) ? CH_SPACE : '0;
		end else if (state_q == ST_READ) begin
			cell_q <= rd_data;
		end
		if (walk_go) begin
			walk_cnt_q <= w_begin;
			walk_end_q <= w_end;
			copy_end_q <= c_end;
		end else if (state_q == ST_WALK) begin
			walk_cnt_q <= walk_cnt_q + CW'(1);
		end
		pend_addr_s1 <= (state_q == ST_WALK) ? AW'(walk_cnt_q) : AW'(cur_addr);
		pend_copy_s1 <= (state_q == ST_WALK) && walk_copy;
		pend_byte_s1 <= (state_q == ST_WALK) ? CH_SPACE : byte_q;
		pend_alt_s1  <= use_alt_q;
	end

	// terminal and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= ROW_W'(1); cur_col_q <= COL_W'(1);
			sav_row_q <= ROW_W'(1); sav_col_q <= COL_W'(1);
			use_alt_q <= 1'b0; needs_full_q <= 1'b1;
			dirty_q <= '0; pmode_q <= PM_TEXT; seq_len_q <= '0; priv_q <= 1'b0;
			field_q <= 2'd0; fv_q <= '0; fs_q <= 1'b0; sv_q <= '0; ss_q <= 1'b0;
			init_cnt_q <= '0; pend_v_s1 <= 1'b0; rdirty_q <= 1'b0;
		end else begin
			if (state_q == ST_INIT) init_cnt_q <= init_cnt_q + CW'(1);
			pend_v_s1 <= (state_q == ST_WALK) || (exec_feed && do_wr);
			// dirty query result, taken before the mark is cleared
			if (state_q == ST_EXEC) begin
				rdirty_q <= (act_q == ACT_DIRTY) && (32'(ridx_q) < MAX_ROWS)
					&& dirty_q[RW'(ridx_q)];
			end
			if (exec_feed) begin
				cur_row_q <= nx_row; cur_col_q <= nx_col;
				sav_row_q <= nx_srow; sav_col_q <= nx_scol;
				use_alt_q <= nx_alt; needs_full_q <= nx_full;
				pmode_q <= nx_pmode; seq_len_q <= nx_slen; priv_q <= nx_priv;
				field_q <= nx_field; fv_q <= nx_fv; fs_q <= nx_fs;
				sv_q <= nx_sv; ss_q <= nx_ss;
				// a scroll or clear marks every row of the screen
				if (do_scroll || do_clear) begin
					for (int r = 0; r < MAX_ROWS; r++) begin
						if (r < 32'(eff_h)) dirty_q[r] <= 1'b1;
					end
				end else if (do_dcur) begin
					dirty_q[RW'(cur_row_q - ROW_W'(1))] <= 1'b1;
				end
			end else if (state_q == ST_EXEC && act_q == ACT_DIRTY) begin
				if (32'(ridx_q) < MAX_ROWS) dirty_q[RW'(ridx_q)] <= 1'b0;
			end else if (state_q == ST_EXEC && act_q == ACT_ACK) begin
				needs_full_q <= 1'b0;
				for (int r = 0; r < MAX_ROWS; r++) begin
					if (r < 32'(eff_h)) dirty_q[r] <= 1'b0;
				end
			end
		end
	end

	// checks
	a_pend_addr: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_s1 |-> 32'(pend_addr_s1) < DEPTH)
		else $error("screen write beyond the memory");
	a_cursor_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q != '0) && (cur_col_q != '0))
		else $error("cursor at zero");
	a_alt_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(use_alt_q) |-> needs_full_q)
		else $error("screen switch without full redraw");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> walk_cnt_q < walk_end_q)
		else $error("memory walk overran its end");
endmodule
`default_nettype wire

### rtl/core/ansi_text_terminal_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_text_terminal_core
// VT100/ANSI subset text terminal: main and alternate screens, cursor,
// escape sequence parser and row dirty marks.
// ----------------------------------------------------------------------------
// After reset the core clears both screens, one cell per cycle, during
// which no item is taken (configuration writes are). An accepted item then
// passes an address multiply state and an execute state, a cell read adding
// a memory read state, before its result is loaded into the output
// register; no new item is taken until then. A byte that scrolls or clears
// the screen walks W*H cells of the active screen memory, one per cycle; an
// erase to end of line walks the cleared cells of the cursor row. A finished
// result waits in the output register while the next item is taken; while
// that register is still full the core holds its result and takes no new
// item.
module ansi_text_terminal_core import atc_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int SEQ_MAX  = SEQ_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	atc_item_if.sink          item_in,
	atc_result_if.source      result_out
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(MAX_COLS + 1);
	localparam int HW    = $clog2(MAX_ROWS + 1);

	logic [9:0]        cfg_w_q;
	logic [7:0]        cfg_h_q;
	logic [EW-1:0]     eff_w;
	logic [HW-1:0]     eff_h;
	mem_ctl_t          mem;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [BYTE_W-1:0] main_rd, alt_rd, rd_data, wr_data;
	logic              res_load, slot_free, out_v_q;
	result_t           res, res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 10'd80;
			cfg_h_q <= 8'd24;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_w_q <= cfg_data;
				REG_HEIGHT: cfg_h_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// registers held to the usable screen size
	always_comb begin
		if (32'(cfg_w_q) < MIN_W) eff_w = EW'(MIN_W);
		else if (32'(cfg_w_q) > MAX_COLS) eff_w = EW'(MAX_COLS);
		else eff_w = EW'(cfg_w_q);
		if (32'(cfg_h_q) < MIN_H) eff_h = HW'(MIN_H);
		else if (32'(cfg_h_q) > MAX_ROWS) eff_h = HW'(MAX_ROWS);
		else eff_h = HW'(cfg_h_q);
	end

	atc_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.SEQ_MAX  (SEQ_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.item_in   (item_in),
		.res_load  (res_load),
		.res       (res),
		.slot_free (slot_free),
		.mem       (mem),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.rd_data   (rd_data)
	);

	// screen memories
	assign rd_data = mem.rd_alt ? alt_rd : main_rd;
	assign wr_data = mem.wr_copy ? rd_data : mem.wr_byte;

	atc_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_main (
		.clk     (clk),
		.we      (mem.we_main),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (mem.rd_en && !mem.rd_alt),
		.rd_addr (rd_addr),
		.rd_data (main_rd)
	);

	atc_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_alt (
		.clk     (clk),
		.we      (mem.we_alt),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (mem.rd_en && mem.rd_alt),
		.rd_addr (rd_addr),
		.rd_data (alt_rd)
	);

	// output register
	assign slot_free = !out_v_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_load) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res;
	end

	assign result_out.valid       = out_v_q;
	assign result_out.cursor_row  = res_q.cursor_row;
	assign result_out.cursor_col  = res_q.cursor_col;
	assign result_out.alt_active  = res_q.alt_active;
	assign result_out.full_redraw = res_q.full_redraw;
	assign result_out.cell_char   = res_q.cell_char;
	assign result_out.row_dirty   = res_q.row_dirty;
endmodule
`default_nettype wire

### verif/ansi_text_terminal_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_terminal_core_tb
// Feeds bytes, escape sequences, cell reads, dirty queries and redraw
// acknowledges through the item channel. A behavioural mirror of the terminal
// predicts the result items, which are checked field by field. Screen
// geometry is changed between phases, extremes and out-of-range values
// included, with random idling and a long receiver stall.
// ----------------------------------------------------------------------------
module ansi_text_terminal_core_tb import atc_pkg::*; ();

	localparam int CELLS      = MAX_COLS_DEF * MAX_ROWS_DEF;
	localparam int WDOG_LIMIT = 300000;

	typedef struct {
		logic [ACT_W-1:0]  act;
		logic [BYTE_W-1:0] dbyte;
		logic [RIDX_W-1:0] ridx;
		logic [CIDX_W-1:0] cidx;
		bit                fixed;
		result_t           res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	atc_item_if   in_if ();
	atc_result_if out_if ();

	ansi_text_terminal_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_in    (in_if),
		.result_out (out_if)
	);

	// mirror of the terminal state
	logic [7:0] scr_main [CELLS];
	logic [7:0] scr_alt [CELLS];
	bit dirty [MAX_ROWS_DEF];
	int cfg_w, cfg_h;
	bit on_alt, need_full, priv;
	int cur_r, cur_c, sav_r, sav_c;
	pmode_t pmode;
	int seq_n, fld, val0, val1;
	bit seen0, seen1;

	result_t pending_res [$];
	int n_err;
	int n_sent;
	bit quiet;
	bit hold;
	bit hold_go;
	int idle_cnt;

	// clock and reset
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int eff_w();
		return (cfg_w < MIN_W) ? MIN_W : (cfg_w > MAX_COLS_DEF) ? MAX_COLS_DEF : cfg_w;
	endfunction

	function automatic int eff_h();
		return (cfg_h < MIN_H) ? MIN_H : (cfg_h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : cfg_h;
	endfunction

	function automatic logic [7:0] cell_rd(int idx);
		return on_alt ? scr_alt[idx] : scr_main[idx];
	endfunction

	function automatic void cell_wr(int idx, logic [7:0] v);
		if (on_alt)
			scr_alt[idx] = v;
		else
			scr_main[idx] = v;
	endfunction

	function automatic void mark_rows();
		for (int r = 0; r < eff_h(); r++)
			dirty[r] = 1'b1;
	endfunction

	function automatic void line_down();
		int w, h;
		w = eff_w();
		h = eff_h();
		if (cur_r < h) begin
			cur_r++;
		end else begin
			// scroll the whole screen up one row
			for (int i = 0; i < (h - 1) * w; i++)
				cell_wr(i, cell_rd(i + w));
			for (int i = (h - 1) * w; i < h * w; i++)
				cell_wr(i, CH_SPACE);
			mark_rows();
		end
	endfunction

	function automatic void wipe_screen();
		for (int i = 0; i < eff_w() * eff_h(); i++)
			cell_wr(i, CH_SPACE);
		mark_rows();
	endfunction

	function automatic void put_text(logic [7:0] b);
		int w, h;
		w = eff_w();
		h = eff_h();
		case (b)
			CH_LF: begin
				line_down();
				cur_c = 1;
			end
			CH_CR: cur_c = 1;
			CH_BS: if (cur_c > 1) cur_c--;
			CH_TAB: begin
				cur_c = ((cur_c + 7) / 8) * 8 + 1;
				if (cur_c > w) cur_c = w;
			end
			CH_NUL: ;
			default: begin
				// characters off the screen are dropped, cursor still moves
				if (cur_r >= 1 && cur_r <= h && cur_c >= 1 && cur_c <= w) begin
					cell_wr((cur_r - 1) * w + cur_c - 1, b);
					dirty[cur_r - 1] = 1'b1;
				end
				cur_c++;
				if (cur_c > w) begin
					cur_c = 1;
					line_down();
				end
			end
		endcase
	endfunction

	function automatic void seq_final(logic [7:0] fin);
		int w, h, p0, p1;
		w = eff_w();
		h = eff_h();
		p0 = seen0 ? val0 : 1;
		p1 = seen1 ? val1 : 1;
		if (priv) begin
			if (p0 != ALT_SCREEN_MODE) return;
			if (fin == FIN_SET) begin
				on_alt = 1'b1;
				sav_r = cur_r;
				sav_c = cur_c;
				cur_r = 1;
				cur_c = 1;
				wipe_screen();
				need_full = 1'b1;
			end else if (fin == FIN_RST) begin
				on_alt = 1'b0;
				cur_r = sav_r;
				cur_c = sav_c;
				need_full = 1'b1;
			end
			return;
		end
		if (fin == FIN_CUP) begin
			cur_r = (seq_n == 0) ? 1 : p0;
			cur_c = (seq_n == 0) ? 1 : p1;
			if (cur_r < 1) cur_r = 1;
			if (cur_r > h) cur_r = h;
			if (cur_c < 1) cur_c = 1;
			if (cur_c > w) cur_c = w;
		end else if (fin == FIN_ED) begin
			if (p0 == 2) wipe_screen();
		end else if (fin == FIN_EL) begin
			if (cur_r >= 1 && cur_r <= h) begin
				for (int c = cur_c - 1; c < w; c++)
					cell_wr((cur_r - 1) * w + c, CH_SPACE);
				dirty[cur_r - 1] = 1'b1;
			end
		end
	endfunction

	function automatic int add_digit(int v, int d);
		int n;
		n = v * 10 + d;
		return (n > PARAM_SAT) ? int'(PARAM_SAT) : n;
	endfunction

	function automatic void feed_byte(logic [7:0] b);
		if (pmode == PM_TEXT) begin
			if (b == CH_ESC)
				pmode = PM_ESC;
			else
				put_text(b);
		end else if (pmode == PM_ESC) begin
			if (b == CH_LBR) begin
				pmode = PM_SEQ;
				seq_n = 0;
				priv = 0;
				fld = 0;
				val0 = 0;
				val1 = 0;
				seen0 = 0;
				seen1 = 0;
			end else begin
				pmode = PM_TEXT;
			end
		end else begin
			if (b >= FIN_LO && b <= FIN_HI) begin
				seq_final(b);
				pmode = PM_TEXT;
			end else if (b == CH_QM) begin
				priv = 1'b1;
			end else if (seq_n < SEQ_MAX_DEF) begin
				seq_n++;
				if (b == CH_SEMI) begin
					if (fld < 2) fld++;
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					if (fld == 0) begin
						val0 = add_digit(val0, b - CH_ZERO);
						seen0 = 1'b1;
					end else if (fld == 1) begin
						val1 = add_digit(val1, b - CH_ZERO);
						seen1 = 1'b1;
					end
				end
			end
		end
	endfunction

	// expected result of one accepted item
	function automatic result_t term_step(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
			logic [RIDX_W-1:0] r, logic [CIDX_W-1:0] c);
		result_t res;
		int w, h;
		res = '0;
		w = eff_w();
		h = eff_h();
		case (act)
			ACT_FEED: feed_byte(b);
			ACT_CELL: res.cell_char = (r < h && c < w) ? cell_rd(r * w + c) : CH_SPACE;
			ACT_DIRTY: begin
				if (r < MAX_ROWS_DEF) begin
					res.row_dirty = dirty[r];
					dirty[r] = 1'b0;
				end
			end
			default: begin
				need_full = 1'b0;
				for (int i = 0; i < h; i++)
					dirty[i] = 1'b0;
			end
		endcase
		res.cursor_row = cur_r[ROW_W-1:0];
		res.cursor_col = cur_c[COL_W-1:0];
		res.alt_active = on_alt;
		res.full_redraw = need_full;
		return res;
	endfunction

	// item sender: random gaps, then hold valid until taken
	task automatic send_item(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
			logic [RIDX_W-1:0] r, logic [CIDX_W-1:0] c, bit fixed = 0,
			result_t fixed_res = '0);
		result_t res;
		if (!quiet && $urandom_range(99) < 25) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.action <= act;
		in_if.data_byte <= b;
		in_if.row_index <= r;
		in_if.col_index <= c;
		do @(posedge clk); while (!in_if.ready);
		res = term_step(act, b, r, c);
		pending_res.push_back(fixed ? fixed_res : res);
		n_sent++;
	endtask

	task automatic send_byte(logic [BYTE_W-1:0] b);
		send_item(ACT_FEED, b, RIDX_W'($urandom), CIDX_W'($urandom));
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_digits(int n);
		for (int i = 0; i < n; i++)
			send_byte(BYTE_W'($urandom_range(CH_ZERO, CH_NINE)));
	endtask

	// well-formed control sequence with random content
	task automatic send_seq();
		int k;
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		if ($urandom_range(99) < 25) send_byte(CH_QM);
		k = $urandom_range(99);
		if (k < 25)
			send_text("1049");
		else if (k < 35)
			send_text("2");
		else if (k < 40)
			send_digits(7);
		else
			send_digits($urandom_range(0, 3));
		if ($urandom_range(99) < 50) begin
			send_byte(CH_SEMI);
			send_digits($urandom_range(0, ($urandom_range(9) == 0) ? 7 : 3));
		end
		if ($urandom_range(99) < 10)
			send_byte(BYTE_W'($urandom_range(8'h20, 8'h3f)));
		// overlong sequence runs past the byte limit
		if ($urandom_range(99) < 4)
			repeat (SEQ_MAX_DEF + 4) send_byte(BYTE_W'($urandom_range(CH_ZERO, CH_SEMI)));
		k = $urandom_range(99);
		if (k < 25)
			send_byte(FIN_CUP);
		else if (k < 35)
			send_byte(FIN_ED);
		else if (k < 50)
			send_byte(FIN_EL);
		else if (k < 65)
			send_byte(FIN_SET);
		else if (k < 80)
			send_byte(FIN_RST);
		else
			send_byte(BYTE_W'($urandom_range(FIN_LO, FIN_HI)));
	endtask

	task automatic run_random(int n_items);
		int stop, x, w, h;
		stop = n_sent + n_items;
		while (n_sent < stop) begin
			x = $urandom_range(99);
			w = eff_w();
			h = eff_h();
			if (x < 35)
				send_seq();
			else if (x < 65)
				send_byte(BYTE_W'($urandom_range(8'h20, 8'h7e)));
			else if (x < 75) begin
				case ($urandom_range(4))
					0: send_byte(CH_LF);
					1: send_byte(CH_CR);
					2: send_byte(CH_BS);
					3: send_byte(CH_TAB);
					default: send_byte(CH_NUL);
				endcase
			end else if (x < 82)
				send_byte(BYTE_W'($urandom));
			else if (x < 86)
				send_item(ACT_CELL, BYTE_W'($urandom), RIDX_W'($urandom), CIDX_W'($urandom));
			else if (x < 90)
				send_item(ACT_CELL, BYTE_W'($urandom), RIDX_W'($urandom_range(0, h)),
					CIDX_W'($urandom_range(0, w)));
			else if (x < 96)
				send_item(ACT_DIRTY, BYTE_W'($urandom), RIDX_W'($urandom), CIDX_W'($urandom));
			else
				send_item(ACT_ACK, BYTE_W'($urandom), RIDX_W'($urandom), CIDX_W'($urandom));
			if (n_sent > 120) hold_go = 1'b1;
		end
	endtask

	// geometry changes only once the core has gone quiet
	task automatic cfg_write(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] v);
		in_if.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH)
			cfg_w = v;
		else
			cfg_h = v[7:0];
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_res.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result item %p", out_if.cursor_row);
			end else begin
				result_t exp_r, got;
				exp_r = pending_res.pop_front();
				got.cursor_row = out_if.cursor_row;
				got.cursor_col = out_if.cursor_col;
				got.alt_active = out_if.alt_active;
				got.full_redraw = out_if.full_redraw;
				got.cell_char = out_if.cell_char;
				got.row_dirty = out_if.row_dirty;
				if (got.cursor_row !== exp_r.cursor_row || got.cursor_col !== exp_r.cursor_col
						|| got.alt_active !== exp_r.alt_active
						|| got.full_redraw !== exp_r.full_redraw
						|| got.cell_char !== exp_r.cell_char
						|| got.row_dirty !== exp_r.row_dirty) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch at %0t: expected %p, got %p", $realtime, exp_r, got);
				end
			end
		end
	end

	// receiver ready: random stalls, a quiet stretch, one long hold-off
	initial out_if.ready = 1'b0;
	always @(posedge clk) begin
		if (!arst_n)
			out_if.ready <= 1'b0;
		else
			out_if.ready <= !hold && (quiet || $urandom_range(99) >= 25);
	end

	initial begin
		hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold = 1'b1;
		repeat (400) @(posedge clk);
		hold = 1'b0;
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("ansi_text_terminal_core_tb: FAIL");
			$finish;
		end
	end

	// main sequence
	initial begin
		stim_row_t tab [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.action = ACT_FEED;
		in_if.data_byte = '0;
		in_if.row_index = '0;
		in_if.col_index = '0;
		n_err = 0;
		n_sent = 0;
		idle_cnt = 0;
		quiet = 1'b0;
		hold_go = 1'b0;
		for (int i = 0; i < CELLS; i++) begin
			scr_main[i] = CH_SPACE;
			scr_alt[i] = CH_SPACE;
		end
		foreach (dirty[i]) dirty[i] = 1'b0;
		cfg_w = 80;
		cfg_h = 24;
		on_alt = 0;
		need_full = 1;
		cur_r = 1;
		cur_c = 1;
		sav_r = 1;
		sav_c = 1;
		pmode = PM_TEXT;
		seq_n = 0;
		priv = 0;
		fld = 0;
		val0 = 0;
		val1 = 0;
		seen0 = 0;
		seen1 = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items: fixed expectations after reset, then predicted
		tab.push_back('{ACT_CELL, 8'h00, 8'd0, 9'd0, 1,
			'{cursor_row: 1, cursor_col: 1, alt_active: 0, full_redraw: 1,
			cell_char: CH_SPACE, row_dirty: 0}});
		tab.push_back('{ACT_CELL, 8'hff, 8'd255, 9'd511, 1,
			'{cursor_row: 1, cursor_col: 1, alt_active: 0, full_redraw: 1,
			cell_char: CH_SPACE, row_dirty: 0}});
		tab.push_back('{ACT_DIRTY, 8'h00, 8'd255, 9'd0, 1,
			'{cursor_row: 1, cursor_col: 1, alt_active: 0, full_redraw: 1,
			cell_char: 0, row_dirty: 0}});
		tab.push_back('{ACT_ACK, 8'h00, 8'd0, 9'd0, 1,
			'{cursor_row: 1, cursor_col: 1, alt_active: 0, full_redraw: 0,
			cell_char: 0, row_dirty: 0}});
		tab.push_back('{ACT_FEED, 8'h41, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, 8'hff, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_DIRTY, 8'h00, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_NUL, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_TAB, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_BS, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_CR, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_LF, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_ESC, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, 8'h78, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_ESC, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, CH_LBR, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_FEED, FIN_CUP, 8'd0, 9'd0, 0, '0});
		tab.push_back('{ACT_CELL, 8'h00, 8'd0, 9'd1, 0, '0});
		foreach (tab[i])
			send_item(tab[i].act, tab[i].dbyte, tab[i].ridx, tab[i].cidx, tab[i].fixed,
				tab[i].res);
		send_text("\033[?1049h");
		send_text("\033[?1049l");

		// default geometry, with the long receiver stall
		run_random(260);

		// narrowest screen, no idling on the sender side
		cfg_write(REG_WIDTH, 10);
		cfg_write(REG_HEIGHT, 5);
		quiet = 1'b1;
		run_random(200);
		quiet = 1'b0;

		// values below range are held at the minimum
		cfg_write(REG_WIDTH, 0);
		cfg_write(REG_HEIGHT, 0);
		run_random(120);

		// widest screen: positioning, a line erase, a write and reads, no scrolling
		cfg_write(REG_WIDTH, 10'h3ff);
		cfg_write(REG_HEIGHT, 8'hff);
		send_text("\033[200;600H");
		send_text("\033[K");
		send_item(ACT_CELL, 8'h00, 8'd199, 9'd511);
		send_text("\033[1;1HQ");
		send_item(ACT_CELL, 8'h00, 8'd0, 9'd0);

		// medium screen
		cfg_write(REG_WIDTH, 33);
		cfg_write(REG_HEIGHT, 7);
		run_random(230);

		in_if.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (n_err == 0)
			$display("ansi_text_terminal_core_tb: PASS");
		else
			$display("ansi_text_terminal_core_tb: FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/atc_pkg.sv
rtl/core/atc_if.sv
rtl/core/atc_ram.sv
rtl/core/atc_ctrl.sv
rtl/core/ansi_text_terminal_core.sv
verif/ansi_text_terminal_core_tb.sv
